>>> sv/calendar_clock_second_tick_top_defines.svh
// Assertion macros used by the calendar clock checker.
`ifndef CALENDAR_CLOCK_SECOND_TICK_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_SECOND_TICK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cct_pkg.sv
// Package: types, constants and month table of the calendar clock.
package cct_pkg;

    localparam int YEAR_BITS_DEF = 12;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;

    localparam int YEAR_RESET = 2000;

    localparam logic [SEC_W-1:0]   SEC_TOP      = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_TOP      = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_TOP     = 5'd23;
    localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_MAX      = 5'd31;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
    localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_TOP    = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;

    // Indexed by the raw 4-bit month; unused codes read 31.
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
    } cal_t;

    typedef struct packed {
        op_t               operation;
        cal_t              load;
        logic [YEAR_W-1:0] year;
    } item_t;

    localparam cal_t CAL_RESET = '{
        second: '0,
        minute: '0,
        hour:   '0,
        day:    DAY_FIRST,
        month:  MONTH_FIRST
    };

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[month];
        if (month == MONTH_FEB && leap)
        begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

endpackage

>>> sv/cct_if.sv
// Channel interfaces: command items in, time items out.
interface cct_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [5:0] load_second;
    logic [5:0] load_minute;
    logic [4:0] load_hour;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [11:0] load_year;

    modport source (
        output valid, operation, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        input  ready
    );
    modport sink (
        input  valid, operation, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        output ready
    );
endinterface

interface cct_time_if;
    logic       valid;
    logic       ready;
    logic [5:0] second_now;
    logic [5:0] minute_now;
    logic [4:0] hour_now;
    logic [4:0] day_now;
    logic [3:0] month_now;
    logic [11:0] year_now;

    modport source (
        output valid, second_now, minute_now, hour_now, day_now, month_now,
               year_now,
        input  ready
    );
    modport sink (
        input  valid, second_now, minute_now, hour_now, day_now, month_now,
               year_now,
        output ready
    );
endinterface

>>> sv/cct_update.sv
// Next-time logic: one-second tick with cascaded carries, or clamped load.
module cct_update #(
    parameter int YEAR_BITS = cct_pkg::YEAR_BITS_DEF
) (
    input  cct_pkg::item_t        item,
    input  cct_pkg::cal_t         cal,
    input  logic [YEAR_BITS-1:0]  year,
    output cct_pkg::cal_t         cal_next,
    output logic [YEAR_BITS-1:0]  year_next
);

    cct_pkg::cal_t                 tick_cal;
    logic [YEAR_BITS-1:0]          tick_year;
    cct_pkg::cal_t                 load_cal;
    logic [YEAR_BITS-1:0]          load_year;
    logic [cct_pkg::DAY_W-1:0]     cur_len;
    logic [cct_pkg::DAY_W-1:0]     load_len;
    logic                          carry_s;
    logic                          carry_m;
    logic                          carry_h;
    logic                          carry_d;
    logic                          carry_mo;

    // tick
    always_comb
    begin
        cur_len  = cct_pkg::days_in(cal.month, year[1:0] == 2'b00);
        carry_s  = cal.second >= cct_pkg::SEC_TOP;
        carry_m  = carry_s && (cal.minute >= cct_pkg::MIN_TOP);
        carry_h  = carry_m && (cal.hour >= cct_pkg::HOUR_TOP);
        carry_d  = carry_h && (cal.day >= cur_len);
        carry_mo = carry_d && (cal.month >= cct_pkg::MONTH_TOP);

        tick_cal  = cal;
        tick_year = year;
        tick_cal.second = carry_s ? '0 : cal.second + 6'd1;
        if (carry_s)
        begin
            tick_cal.minute = carry_m ? '0 : cal.minute + 6'd1;
        end
        if (carry_m)
        begin
            tick_cal.hour = carry_h ? '0 : cal.hour + 5'd1;
        end
        if (carry_h)
        begin
            tick_cal.day = carry_d ? cct_pkg::DAY_FIRST : cal.day + 5'd1;
        end
        if (carry_d)
        begin
            tick_cal.month = carry_mo ? cct_pkg::MONTH_FIRST : cal.month + 4'd1;
        end
        if (carry_mo)
        begin
            tick_year = year + YEAR_BITS'(1);
        end
    end

    // load with clamping
    always_comb
    begin
        load_year = YEAR_BITS'(item.year);

        load_cal.second = (item.load.second > cct_pkg::SEC_TOP) ? cct_pkg::SEC_TOP
                                                                : item.load.second;
        load_cal.minute = (item.load.minute > cct_pkg::MIN_TOP) ? cct_pkg::MIN_TOP
                                                                : item.load.minute;
        load_cal.hour   = (item.load.hour > cct_pkg::HOUR_TOP) ? cct_pkg::HOUR_TOP
                                                               : item.load.hour;

        priority if (item.load.month > cct_pkg::MONTH_TOP)
        begin
            load_cal.month = cct_pkg::MONTH_TOP;
        end
        else if (item.load.month == '0)
        begin
            load_cal.month = cct_pkg::MONTH_FIRST;
        end
        else
        begin
            load_cal.month = item.load.month;
        end

        load_len = cct_pkg::days_in(load_cal.month, load_year[1:0] == 2'b00);

        priority if (item.load.day > load_len)
        begin
            load_cal.day = load_len;
        end
        else if (item.load.day == '0)
        begin
            load_cal.day = cct_pkg::DAY_FIRST;
        end
        else
        begin
            load_cal.day = item.load.day;
        end
    end

    always_comb
    begin
        unique case (item.operation)
            cct_pkg::OP_TICK:
            begin
                cal_next  = tick_cal;
                year_next = tick_year;
            end
            cct_pkg::OP_LOAD:
            begin
                cal_next  = load_cal;
                year_next = load_year;
            end
            default:
            begin
                cal_next  = tick_cal;
                year_next = tick_year;
            end
        endcase
    end

endmodule

>>> sv/calendar_clock_second_tick_top.sv
// Calendar clock top level: input register, next-time logic, time register.
//
// cmd carries one item per handshake: operation selects a one-second tick
// or a load of the full date and time (loaded values are clamped into range,
// the day to the length of the loaded month). Every item yields exactly one
// item on stamp: the date and time after that command.
// An accepted command is held in the input register; the time
// register is updated from it when stamp is not stalled, and the result
// is then offered on stamp until it is taken.
// One item per cycle is sustained while stamp is not stalled; the limit
// is the single tick/load update of the time register.
// The time register doubles as the output register: it changes only when
// its current value has been taken or was never offered.
// Reset: 00:00:00, day 1, month 1, year 2000 modulo 2^YEAR_BITS; no result
// is pending. If stamp stalls, one more command is held in the input
// register and cmd.ready then drops until the stall clears.
module calendar_clock_second_tick_top #(
    parameter int YEAR_BITS = cct_pkg::YEAR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cct_item_if.sink    cmd,
    cct_time_if.source  stamp
);

    localparam logic [YEAR_BITS-1:0] YEAR_INIT = YEAR_BITS'(cct_pkg::YEAR_RESET);

    logic                  s1_valid_reg;
    cct_pkg::item_t        s1_item_reg;
    cct_pkg::cal_t         cal_reg;
    logic [YEAR_BITS-1:0]  year_reg;
    logic                  out_valid_reg;
    cct_pkg::cal_t         cal_next;
    logic [YEAR_BITS-1:0]  year_next;
    logic                  advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || stamp.ready);
    assign cmd.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg.operation   <= cct_pkg::op_t'(cmd.operation);
            s1_item_reg.load.second <= cmd.load_second;
            s1_item_reg.load.minute <= cmd.load_minute;
            s1_item_reg.load.hour   <= cmd.load_hour;
            s1_item_reg.load.day    <= cmd.load_day;
            s1_item_reg.load.month  <= cmd.load_month;
            s1_item_reg.year        <= cmd.load_year;
        end
    end

    cct_update #(
        .YEAR_BITS (YEAR_BITS)
    ) u_update (
        .item      (s1_item_reg),
        .cal       (cal_reg),
        .year      (year_reg),
        .cal_next  (cal_next),
        .year_next (year_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg       <= cct_pkg::CAL_RESET;
            year_reg      <= YEAR_INIT;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cal_reg       <= cal_next;
            year_reg      <= year_next;
            out_valid_reg <= 1'b1;
        end
        else if (stamp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stamp.valid      = out_valid_reg;
    assign stamp.second_now = cal_reg.second;
    assign stamp.minute_now = cal_reg.minute;
    assign stamp.hour_now   = cal_reg.hour;
    assign stamp.day_now    = cal_reg.day;
    assign stamp.month_now  = cal_reg.month;
    assign stamp.year_now   = cct_pkg::YEAR_W'(year_reg);

endmodule

>>> sv/cct_checker.sv
// Port-level checker for the calendar clock, bound to the top level.
`include "calendar_clock_second_tick_top_defines.svh"

module cct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  second,
    input logic [5:0]  minute,
    input logic [4:0]  hour,
    input logic [4:0]  day,
    input logic [3:0]  month,
    input logic [11:0] year
);

    `CCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `CCT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable({second, minute, hour, day, month, year}), "stalled result changed")
    `CCT_ASSERT_IMP(a_ready_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input blocked without output stall")
    `CCT_ASSERT_NEXT(a_in_to_out, clk, rst_n, in_valid && in_ready, ##1 out_valid, "no result after accepted item")
    `CCT_ASSERT_IMP(a_range, clk, rst_n, out_valid, (second <= cct_pkg::SEC_TOP) && (minute <= cct_pkg::MIN_TOP) && (hour <= cct_pkg::HOUR_TOP) && (day >= cct_pkg::DAY_FIRST) && (month >= cct_pkg::MONTH_FIRST) && (month <= cct_pkg::MONTH_TOP), "time field out of range")

endmodule

bind calendar_clock_second_tick_top cct_checker u_cct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (stamp.valid),
    .out_ready (stamp.ready),
    .second    (stamp.second_now),
    .minute    (stamp.minute_now),
    .hour      (stamp.hour_now),
    .day       (stamp.day_now),
    .month     (stamp.month_now),
    .year      (stamp.year_now)
);
